[rtl/tpe_pkg.sv]
// Shared types and constants for the two-level precedence evaluator.
// Holds operator codes, selector enums, FSM states and the command/status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tpe_pkg;

  // Default datapath width
  localparam int WIDTH_DEFAULT = 32;

  // Operator codes on the next_op field
  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_EQ  = 3'd4;

  // Arithmetic unit operation, also the stored operator code
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  // Operand and operator selectors of the arithmetic unit
  typedef enum logic {
    SRC_A_LEFT   = 1'b0,
    SRC_A_MIDDLE = 1'b1
  } src_a_t;

  typedef enum logic {
    SRC_B_MIDDLE = 1'b0,
    SRC_B_INPUT  = 1'b1
  } src_b_t;

  typedef enum logic {
    OP_SRC_LEFT  = 1'b0,
    OP_SRC_RIGHT = 1'b1
  } op_src_t;

  // Expression fill level
  typedef enum logic [1:0] {
    PH_EMPTY = 2'd0,
    PH_ONE   = 2'd1,
    PH_TWO   = 2'd2
  } phase_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE      = 3'd0,
    ST_DECODE    = 3'd1,
    ST_WAIT_MID  = 3'd2,
    ST_WAIT_LEFT = 3'd3,
    ST_POST      = 3'd4,
    ST_WAIT_FIN  = 3'd5,
    ST_FINISH    = 3'd6
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic    in_load;
    logic    alu_start;
    src_a_t  a_sel;
    src_b_t  b_sel;
    op_src_t op_sel;
    logic    left_from_in;
    logic    mid_from_in;
    logic    mid_from_alu;
    logic    left_from_alu;
    logic    rop_load;
    logic    fin_from_in;
    logic    fin_from_alu;
    logic    out_load;
    logic    clear;
  } tpe_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic    eq;
    alu_op_t lop;
    alu_op_t rop;
    logic    alu_done;
    logic    out_free;
  } tpe_status_t;

endpackage

`default_nettype wire

[rtl/tpe_alu.sv]
// Arithmetic unit: add/subtract registered straight from start, bit-serial multiply and divide.
// Uses tpe_pkg for the operation codes.
`timescale 1ns / 1ps
`default_nettype none

module tpe_alu #(
  parameter int WIDTH = tpe_pkg::WIDTH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire tpe_pkg::alu_op_t      op,
  input  wire logic [WIDTH-1:0]      a,
  input  wire logic [WIDTH-1:0]      b,
  output logic                       done,
  output logic [WIDTH-1:0]           res,
  output logic                       dz
);

  localparam int CW = $clog2(WIDTH + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic             kind_div;
  logic             neg;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] x;
  logic [WIDTH-1:0] y;

  logic [WIDTH-1:0] abs_a;
  logic [WIDTH-1:0] abs_b;
  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;

  // Magnitudes and one restoring-division step
  always_comb begin
    abs_a   = a[WIDTH-1] ? (~a + 1'b1) : a;
    abs_b   = b[WIDTH-1] ? (~b + 1'b1) : b;
    shifted = {acc, x[WIDTH-1]};
    diff    = shifted - {1'b0, y};
  end

  // Sequence control: busy, step count, completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        unique case (op)
          tpe_pkg::ALU_ADD, tpe_pkg::ALU_SUB: begin
            done <= 1'b1;
          end
          tpe_pkg::ALU_MUL: begin
            busy <= 1'b1;
            cnt  <= CW'(WIDTH);
          end
          tpe_pkg::ALU_DIV: begin
            if (b == '0) begin
              done <= 1'b1;
            end else begin
              busy <= 1'b1;
              cnt  <= CW'(WIDTH);
            end
          end
          default: begin
            done <= 1'b1;
          end
        endcase
      end else if (busy) begin
        if (cnt != '0) begin
          cnt <= cnt - 1'b1;
        end else begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operand, partial result and result registers
  always_ff @(posedge clk) begin
    if (start) begin
      dz <= 1'b0;
      unique case (op)
        tpe_pkg::ALU_ADD: res <= a + b;
        tpe_pkg::ALU_SUB: res <= a - b;
        tpe_pkg::ALU_MUL: begin
          kind_div <= 1'b0;
          acc      <= '0;
          x        <= a;
          y        <= b;
        end
        tpe_pkg::ALU_DIV: begin
          if (b == '0) begin
            res <= '0;
            dz  <= 1'b1;
          end else begin
            kind_div <= 1'b1;
            neg      <= a[WIDTH-1] ^ b[WIDTH-1];
            acc      <= '0;
            x        <= abs_a;
            y        <= abs_b;
          end
        end
        default: res <= '0;
      endcase
    end else if (busy) begin
      if (cnt != '0) begin
        if (kind_div) begin
          // Shift in one dividend bit, keep the remainder if the trial is non-negative
          if (!diff[WIDTH]) begin
            acc <= diff[WIDTH-1:0];
          end else begin
            acc <= shifted[WIDTH-1:0];
          end
          x <= {x[WIDTH-2:0], ~diff[WIDTH]};
        end else begin
          // Add the shifted multiplicand for each set multiplier bit
          if (y[0]) begin
            acc <= acc + x;
          end
          x <= {x[WIDTH-2:0], 1'b0};
          y <= {1'b0, y[WIDTH-1:1]};
        end
      end else begin
        if (kind_div) begin
          res <= neg ? (~x + 1'b1) : x;
        end else begin
          res <= acc;
        end
      end
    end
  end

endmodule

`default_nettype wire

[rtl/tpe_datapath.sv]
// Datapath: input capture, left/middle values, operators, error flag and output register.
// Uses tpe_pkg and instantiates tpe_alu.
`timescale 1ns / 1ps
`default_nettype none

module tpe_datapath #(
  parameter int WIDTH = tpe_pkg::WIDTH_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire tpe_pkg::tpe_cmd_t    cmd,
  output tpe_pkg::tpe_status_t      status,
  input  wire logic signed [31:0]   operand,
  input  wire logic [2:0]           next_op,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [31:0]        value,
  output logic                      div_zero
);

  logic [WIDTH-1:0]  in_v;
  logic [1:0]        in_op;
  logic              in_eq;
  logic [WIDTH-1:0]  left;
  logic [WIDTH-1:0]  middle;
  tpe_pkg::alu_op_t  lop;
  tpe_pkg::alu_op_t  rop;
  logic              error_seen;
  logic [WIDTH-1:0]  fin_val;

  logic signed [63:0] op_ext;
  logic signed [63:0] fin_ext;
  logic [WIDTH-1:0]   alu_a;
  logic [WIDTH-1:0]   alu_b;
  tpe_pkg::alu_op_t   alu_op;
  logic               alu_done;
  logic [WIDTH-1:0]   alu_res;
  logic               alu_dz;

  // Sign-extend the operand, then wrap to WIDTH; same for the result going out
  always_comb begin
    op_ext  = 64'(operand);
    fin_ext = 64'(signed'(fin_val));
  end

  // Select arithmetic operands and operator
  always_comb begin
    alu_a  = (cmd.a_sel == tpe_pkg::SRC_A_LEFT) ? left : middle;
    alu_b  = (cmd.b_sel == tpe_pkg::SRC_B_MIDDLE) ? middle : in_v;
    alu_op = (cmd.op_sel == tpe_pkg::OP_SRC_LEFT) ? lop : rop;
  end

  tpe_alu #(
    .WIDTH(WIDTH)
  ) u_alu (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.alu_start),
    .op    (alu_op),
    .a     (alu_a),
    .b     (alu_b),
    .done  (alu_done),
    .res   (alu_res),
    .dz    (alu_dz)
  );

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      in_v  <= op_ext[WIDTH-1:0];
      in_op <= next_op[1:0];
      in_eq <= (next_op >= tpe_pkg::OP_EQ);
    end
  end

  // Expression state
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      left       <= '0;
      middle     <= '0;
      lop        <= tpe_pkg::ALU_ADD;
      rop        <= tpe_pkg::ALU_ADD;
      error_seen <= 1'b0;
    end else begin
      if (cmd.left_from_in) begin
        left <= in_v;
        lop  <= tpe_pkg::alu_op_t'(in_op);
      end
      if (cmd.mid_from_in) begin
        middle <= in_v;
        rop    <= tpe_pkg::alu_op_t'(in_op);
      end
      if (cmd.mid_from_alu) begin
        middle <= alu_res;
      end
      if (cmd.left_from_alu) begin
        left   <= alu_res;
        middle <= in_v;
        lop    <= rop;
      end
      if (cmd.rop_load) begin
        rop <= tpe_pkg::alu_op_t'(in_op);
      end
      if (alu_done && alu_dz) begin
        error_seen <= 1'b1;
      end
    end
  end

  // Hold the final value until the output slot frees
  always_ff @(posedge clk) begin
    if (cmd.fin_from_in) begin
      fin_val <= in_v;
    end else if (cmd.fin_from_alu) begin
      fin_val <= alu_res;
    end
  end

  // Output register and its valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      value    <= fin_ext[31:0];
      div_zero <= error_seen;
    end
  end

  // Report status to the controller
  always_comb begin
    status.eq       = in_eq;
    status.lop      = lop;
    status.rop      = rop;
    status.alu_done = alu_done;
    status.out_free = !out_valid || out_ready;
  end

endmodule

`default_nettype wire

[rtl/tpe_controller.sv]
// Controller: sequences the folds of one transaction and tracks the expression phase.
// Uses tpe_pkg for states, phases and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module tpe_controller (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire tpe_pkg::tpe_status_t  status,
  output tpe_pkg::tpe_cmd_t          cmd
);

  tpe_pkg::state_t state;
  tpe_pkg::state_t state_next;
  tpe_pkg::phase_t phase;
  tpe_pkg::phase_t phase_next;
  logic            right_first;

  // Multiply or divide on the right binds before add or subtract on the left
  always_comb begin
    right_first = (status.lop == tpe_pkg::ALU_ADD || status.lop == tpe_pkg::ALU_SUB) &&
                  (status.rop == tpe_pkg::ALU_MUL || status.rop == tpe_pkg::ALU_DIV);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpe_pkg::ST_IDLE;
      phase <= tpe_pkg::PH_EMPTY;
    end else begin
      state <= state_next;
      phase <= phase_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      tpe_pkg::ST_IDLE: begin
        if (in_valid) state_next = tpe_pkg::ST_DECODE;
      end
      tpe_pkg::ST_DECODE: begin
        unique case (phase)
          tpe_pkg::PH_ONE: begin
            state_next = status.eq ? tpe_pkg::ST_WAIT_FIN : tpe_pkg::ST_IDLE;
          end
          tpe_pkg::PH_TWO: begin
            state_next = right_first ? tpe_pkg::ST_WAIT_MID : tpe_pkg::ST_WAIT_LEFT;
          end
          default: begin
            state_next = status.eq ? tpe_pkg::ST_FINISH : tpe_pkg::ST_IDLE;
          end
        endcase
      end
      tpe_pkg::ST_WAIT_MID, tpe_pkg::ST_WAIT_LEFT: begin
        if (status.alu_done) state_next = tpe_pkg::ST_POST;
      end
      tpe_pkg::ST_POST: begin
        state_next = status.eq ? tpe_pkg::ST_WAIT_FIN : tpe_pkg::ST_IDLE;
      end
      tpe_pkg::ST_WAIT_FIN: begin
        if (status.alu_done) state_next = tpe_pkg::ST_FINISH;
      end
      tpe_pkg::ST_FINISH: begin
        if (status.out_free) state_next = tpe_pkg::ST_IDLE;
      end
      default: state_next = tpe_pkg::ST_IDLE;
    endcase
  end

  // Commands and phase update
  always_comb begin
    cmd        = '0;
    phase_next = phase;
    in_ready   = (state == tpe_pkg::ST_IDLE);
    unique case (state)
      tpe_pkg::ST_IDLE: begin
        cmd.in_load = in_valid;
      end
      tpe_pkg::ST_DECODE: begin
        unique case (phase)
          tpe_pkg::PH_ONE: begin
            if (status.eq) begin
              // left op operand, then finish
              cmd.alu_start = 1'b1;
              cmd.a_sel     = tpe_pkg::SRC_A_LEFT;
              cmd.b_sel     = tpe_pkg::SRC_B_INPUT;
              cmd.op_sel    = tpe_pkg::OP_SRC_LEFT;
            end else begin
              cmd.mid_from_in = 1'b1;
              phase_next      = tpe_pkg::PH_TWO;
            end
          end
          tpe_pkg::PH_TWO: begin
            cmd.alu_start = 1'b1;
            if (right_first) begin
              cmd.a_sel  = tpe_pkg::SRC_A_MIDDLE;
              cmd.b_sel  = tpe_pkg::SRC_B_INPUT;
              cmd.op_sel = tpe_pkg::OP_SRC_RIGHT;
            end else begin
              cmd.a_sel  = tpe_pkg::SRC_A_LEFT;
              cmd.b_sel  = tpe_pkg::SRC_B_MIDDLE;
              cmd.op_sel = tpe_pkg::OP_SRC_LEFT;
            end
          end
          default: begin
            // Empty expression: a lone operand before equals goes straight out
            if (status.eq) begin
              cmd.fin_from_in = 1'b1;
            end else begin
              cmd.left_from_in = 1'b1;
              phase_next       = tpe_pkg::PH_ONE;
            end
          end
        endcase
      end
      tpe_pkg::ST_WAIT_MID: begin
        cmd.mid_from_alu = status.alu_done;
      end
      tpe_pkg::ST_WAIT_LEFT: begin
        cmd.left_from_alu = status.alu_done;
      end
      tpe_pkg::ST_POST: begin
        if (status.eq) begin
          cmd.alu_start = 1'b1;
          cmd.a_sel     = tpe_pkg::SRC_A_LEFT;
          cmd.b_sel     = tpe_pkg::SRC_B_MIDDLE;
          cmd.op_sel    = tpe_pkg::OP_SRC_LEFT;
        end else begin
          cmd.rop_load = 1'b1;
        end
      end
      tpe_pkg::ST_WAIT_FIN: begin
        cmd.fin_from_alu = status.alu_done;
      end
      tpe_pkg::ST_FINISH: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.clear    = 1'b1;
          phase_next   = tpe_pkg::PH_EMPTY;
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/two_level_precedence_evaluator_core.sv]
// Two-level precedence infix evaluator, top level.
// Instantiates tpe_controller and tpe_datapath; uses tpe_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one operand and the operator that
//   follows it (0 add, 1 subtract, 2 multiply, 3 divide, 4..7 equals). Output
//   channel (out_valid/out_ready) carries one transaction per expression: the
//   value wrapped to WIDTH bits, sign-extended or cut to 32, and div_zero.
//   Sequence: an item that only stores values is decoded and the controller
//   returns to idle; a lone operand before equals goes straight to the finish
//   step. Add and subtract folds (and a divide by zero) complete directly in
//   the arithmetic unit, multiply and divide folds run through the bit-serial
//   unit; an item folds at most twice.
//   The output is registered: a waiting result does not block the next item
//   until that item itself produces a result, which then holds in the finish
//   step while out_ready is low.
//   Reset (rst, synchronous) empties the expression, clears the error flag
//   and drops out_valid.
`timescale 1ns / 1ps
`default_nettype none

module two_level_precedence_evaluator_core #(
  parameter int WIDTH = tpe_pkg::WIDTH_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [31:0] operand,
  input  wire logic [2:0]         next_op,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      value,
  output logic                    div_zero
);

  tpe_pkg::tpe_cmd_t    cmd;
  tpe_pkg::tpe_status_t status;

  // Sequence each transaction
  tpe_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Hold values and compute
  tpe_datapath #(
    .WIDTH(WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .operand   (operand),
    .next_op   (next_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .div_zero  (div_zero)
  );

endmodule

`default_nettype wire
